FILE: rtl/assert_macros.svh
// Assertion macros shared by the packet reorder sorter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("prs assertion failed");

// Condition must never be true outside reset.
`define PRS_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("prs forbidden condition seen");

`endif

FILE: rtl/prs_pkg.sv
// Package for the packet reorder sorter: field widths, reset values,
// sequencer states and the record store control struct. No dependencies.
package prs_pkg;

    localparam int ID_W          = 16;
    localparam int IN_PAYLOAD_W  = 32;
    localparam int OUT_PAYLOAD_W = 32;
    localparam int CFG_W         = 7;
    localparam int DATA_W        = 48;

    localparam logic [CFG_W-1:0] RECORD_COUNT_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_OUTER_RD,
        ST_OUTER_LD,
        ST_INNER,
        ST_OUTER_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_DONE
    } prs_state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

FILE: rtl/prs_ram.sv
// Record store for the packet reorder sorter: one write port and one
// registered read port. Depends on prs_pkg for the control struct.
module prs_ram
    import prs_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int WIDTH   = 48,
    parameter int ADDR_W  = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  ram_ctl_t          ctl,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/packet_reorder_sorter.sv
// Packet reorder sorter top level: load, exchange sort and emit sequencer.
// Depends on prs_pkg, prs_ram and assert_macros.svh.
//
// The block collects up to record_count packet words (identifier plus
// payload) into an internal store at one word per cycle, then reorders the
// store by identifier with an in-place exchange sort (for each position i
// every later position k is compared and the pair swapped when id[i] >
// id[k]; equal identifiers may change their order), and finally
// streams the records out in sorted order with tlast on the final one.
// After that run the block accepts and drops every further input word
// until reset. The sort runs on one shared comparator against a store with
// one read and one write port: position i is held in a register while each
// later record is read, compared and, on a swap, written back, one compare
// per cycle. s_tready is low from the word that completes the load until
// the last record has entered the output register. record_count may only
// be written while the block is idle; 0 is taken as 1 and values above
// MAX_RECORDS as MAX_RECORDS.
module packet_reorder_sorter
    import prs_pkg::*;
#(
    parameter int MAX_RECORDS  = 64,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    // configuration write: record_count
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data,

    // input words
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_W-1:0]    s_tdata,   // [15:0] packet_id, [47:16] payload_word

    // sorted records
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_W-1:0]    m_tdata,   // [15:0] sorted_id, [47:16] sorted_payload
    output logic                 m_tlast    // last_record
);

`include "assert_macros.svh"

    localparam int IDX_W = $clog2(MAX_RECORDS);
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);
    localparam int REC_W = ID_W + PAYLOAD_BITS;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    prs_state_t               state_reg,        state_next;
    logic [CFG_W-1:0]         record_count_reg;
    logic [CNT_W-1:0]         loaded_count_reg, loaded_count_next;
    logic [CNT_W-1:0]         n_reg,            n_next;
    logic [IDX_W-1:0]         i_reg,            i_next;   // outer position
    logic [IDX_W-1:0]         k_reg,            k_next;   // inner / emit position
    logic [ID_W-1:0]          cur_id_reg,       cur_id_next;
    logic [PAYLOAD_BITS-1:0]  cur_pay_reg,      cur_pay_next;
    logic                     out_valid_reg,    out_valid_next;
    logic [ID_W-1:0]          out_id_reg,       out_id_next;
    logic [OUT_PAYLOAD_W-1:0] out_pay_reg,      out_pay_next;
    logic                     out_last_reg,     out_last_next;

    // ---------------------------------------------------------------
    // Record store
    // ---------------------------------------------------------------
    ram_ctl_t                 ram_ctl;
    logic [IDX_W-1:0]         wr_addr;
    logic [REC_W-1:0]         wr_data;
    logic [IDX_W-1:0]         rd_addr;
    logic [REC_W-1:0]         rd_data;
    logic [ID_W-1:0]          rd_id;
    logic [PAYLOAD_BITS-1:0]  rd_pay;

    prs_ram #(
        .DEPTH  (MAX_RECORDS),
        .WIDTH  (REC_W),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .ctl     (ram_ctl),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Store layout: identifier in the low bits, payload above it.
    assign rd_id  = rd_data[ID_W-1:0];
    assign rd_pay = rd_data[REC_W-1:ID_W];

    // ---------------------------------------------------------------
    // Configuration register: always ready; to be written only when idle, which the block itself does not enforce.
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_count_reg <= RECORD_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            record_count_reg <= cfg_data;
        end
    end

    // Clamp the programmed count into 1..MAX_RECORDS.
    logic [CNT_W-1:0] eff_count;
    always_comb
    begin
        if (record_count_reg == '0)
        begin
            eff_count = CNT_W'(1);
        end
        else if (int'(record_count_reg) > MAX_RECORDS)
        begin
            eff_count = CNT_W'(MAX_RECORDS);
        end
        else
        begin
            eff_count = CNT_W'(record_count_reg);
        end
    end

    // ---------------------------------------------------------------
    // Handshake decode
    // ---------------------------------------------------------------
    logic in_accept;
    logic out_free;
    logic swap;

    assign s_tready  = (state_reg == ST_LOAD) || (state_reg == ST_DONE);
    assign in_accept = s_tvalid && s_tready;
    // Output register can take a new record when empty or being drained.
    assign out_free  = !out_valid_reg || m_tready;
    // Shared comparator: held outer record against the record just read.
    assign swap      = cur_id_reg > rd_id;

    // Position arithmetic widened to count width for compares against n.
    logic [CNT_W-1:0] i_plus2;
    logic [CNT_W-1:0] k_plus1;
    assign i_plus2 = CNT_W'(i_reg) + CNT_W'(2);
    assign k_plus1 = CNT_W'(k_reg) + CNT_W'(1);

    // ---------------------------------------------------------------
    // Sequencer: next state and datapath controls
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next        = state_reg;
        loaded_count_next = loaded_count_reg;
        n_next            = n_reg;
        i_next            = i_reg;
        k_next            = k_reg;
        cur_id_next       = cur_id_reg;
        cur_pay_next      = cur_pay_reg;
        out_id_next       = out_id_reg;
        out_pay_next      = out_pay_reg;
        out_last_next     = out_last_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        ram_ctl           = '0;
        wr_addr           = '0;
        wr_data           = '0;
        rd_addr           = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept)
                begin
                    // Store the word unless the count is already met; drop it otherwise.
                    if (loaded_count_reg < eff_count)
                    begin
                        ram_ctl.wr_en     = 1'b1;
                        wr_addr           = loaded_count_reg[IDX_W-1:0];
                        wr_data           = {PAYLOAD_BITS'(s_tdata[DATA_W-1:ID_W]),
                                             s_tdata[ID_W-1:0]};
                        loaded_count_next = loaded_count_reg + CNT_W'(1);
                    end
                    if (loaded_count_next >= eff_count)
                    begin
                        n_next = eff_count;
                        i_next = '0;
                        k_next = '0;
                        if (eff_count == CNT_W'(1))
                        begin
                            state_next = ST_EMIT_RD;
                        end
                        else
                        begin
                            state_next = ST_OUTER_RD;
                        end
                    end
                end
            end

            ST_OUTER_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = i_reg;
                state_next    = ST_OUTER_LD;
            end

            ST_OUTER_LD:
            begin
                // Hold record i and fetch the first later record.
                cur_id_next   = rd_id;
                cur_pay_next  = rd_pay;
                ram_ctl.rd_en = 1'b1;
                rd_addr       = i_reg + IDX_W'(1);
                k_next        = i_reg + IDX_W'(1);
                state_next    = ST_INNER;
            end

            ST_INNER:
            begin
                if (swap)
                begin
                    ram_ctl.wr_en = 1'b1;
                    wr_addr       = k_reg;
                    wr_data       = {cur_pay_reg, cur_id_reg};
                    cur_id_next   = rd_id;
                    cur_pay_next  = rd_pay;
                end
                if (k_plus1 < n_reg)
                begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = k_plus1[IDX_W-1:0];
                    k_next        = k_plus1[IDX_W-1:0];
                end
                else
                begin
                    state_next = ST_OUTER_WR;
                end
            end

            ST_OUTER_WR:
            begin
                // Write back the minimum for position i, then fetch the next i or start emitting.
                ram_ctl.wr_en = 1'b1;
                wr_addr       = i_reg;
                wr_data       = {cur_pay_reg, cur_id_reg};
                if (i_plus2 < n_reg)
                begin
                    ram_ctl.rd_en = 1'b1;
                    rd_addr       = i_reg + IDX_W'(1);
                    i_next        = i_reg + IDX_W'(1);
                    state_next    = ST_OUTER_LD;
                end
                else
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
            end

            ST_EMIT_RD:
            begin
                ram_ctl.rd_en = 1'b1;
                rd_addr       = k_reg;
                state_next    = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = rd_id;
                    out_pay_next   = OUT_PAYLOAD_W'(rd_pay);
                    out_last_next  = (k_plus1 == n_reg);
                    if (k_plus1 == n_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // Prefetch the next record while this one drains.
                        ram_ctl.rd_en = 1'b1;
                        rd_addr       = k_plus1[IDX_W-1:0];
                        k_next        = k_plus1[IDX_W-1:0];
                    end
                end
            end

            ST_DONE:
            begin
                // Accept and drop every word until reset.
                state_next = ST_DONE;
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            loaded_count_reg <= '0;
            n_reg            <= '0;
            i_reg            <= '0;
            k_reg            <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            loaded_count_reg <= loaded_count_next;
            n_reg            <= n_next;
            i_reg            <= i_next;
            k_reg            <= k_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_id_reg   <= cur_id_next;
        cur_pay_reg  <= cur_pay_next;
        out_id_reg   <= out_id_next;
        out_pay_reg  <= out_pay_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pay_reg, out_id_reg};
    assign m_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `PRS_ASSERT(a_done_sticky, clk, rst_n,
        (state_reg == ST_DONE) |=> (state_reg == ST_DONE))
    `PRS_ASSERT(a_last_means_done, clk, rst_n,
        (m_tvalid && m_tlast) |-> (state_reg == ST_DONE))
    `PRS_ASSERT(a_inner_after_outer, clk, rst_n,
        (state_reg == ST_INNER) |-> (k_reg > i_reg))
    `PRS_NEVER(a_load_bound, clk, rst_n,
        int'(loaded_count_reg) > MAX_RECORDS)

endmodule

FILE: dv/packet_reorder_sorter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for packet_reorder_sorter: streams packet words in,
// predicts the sorted record run and checks every output word against it.
// Depends on prs_pkg and the packet_reorder_sorter RTL only.
module packet_reorder_sorter_tb;
    import prs_pkg::*;

    localparam int MAX_RECORDS = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int TAIL_CYCLES = 200;
    localparam int AFTER_RUN_WORDS = 408;

    // one expected output word
    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [OUT_PAYLOAD_W-1:0] payload;
        logic                     is_last;
    } sorted_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;     // [15:0] packet_id, [47:16] payload_word

    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;     // [15:0] sorted_id, [47:16] sorted_payload
    logic              m_tlast;     // last_record

    packet_reorder_sorter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Sorter shadow: record store, load counter, count register, run flag
    // ------------------------------------------------------------------
    logic [ID_W-1:0]          held_id      [MAX_RECORDS];
    logic [OUT_PAYLOAD_W-1:0] held_payload [MAX_RECORDS];
    int unsigned              held_count    = 0;
    logic [CFG_W-1:0]         count_setting = RECORD_COUNT_RESET;
    bit                       run_done      = 1'b0;

    sorted_rec_t sorted_expect[$];      // records still owed by the block
    logic [DATA_W-1:0] pending_words[$]; // words waiting for the driver

    int fail_count      = 0;
    int words_accepted  = 0;
    int words_dropped   = 0;
    int records_checked = 0;
    int cfg_writes      = 0;
    int cycle_count     = 0;

    // Take one accepted word: store it while loading, drop it after the run,
    // and once the load completes, exchange-sort the store and queue the whole sorted run.
    task automatic absorb_packet(input logic [DATA_W-1:0] word);
        int unsigned              limit;
        logic [ID_W-1:0]          tmp_id;
        logic [OUT_PAYLOAD_W-1:0] tmp_payload;
        sorted_rec_t              rec;
        if (run_done)
        begin
            words_dropped++;
            return;
        end
        // zero counts as one, anything above the store size as the store size
        limit = count_setting;
        if (limit < 1)
            limit = 1;
        if (limit > MAX_RECORDS)
            limit = MAX_RECORDS;
        if (held_count < limit)
        begin
            held_id[held_count]      = word[ID_W-1:0];
            held_payload[held_count] = word[DATA_W-1:ID_W];
            held_count++;
        end
        else
            words_dropped++;    // count was lowered to or below what is held
        if (held_count < limit)
            return;
        // strict compare, matching the swap condition of the block
        for (int i = 0; i < limit; i++)
            for (int k = i + 1; k < limit; k++)
                if (held_id[i] > held_id[k])
                begin
                    tmp_id          = held_id[i];
                    tmp_payload     = held_payload[i];
                    held_id[i]      = held_id[k];
                    held_payload[i] = held_payload[k];
                    held_id[k]      = tmp_id;
                    held_payload[k] = tmp_payload;
                end
        for (int k = 0; k < limit; k++)
        begin
            rec.id      = held_id[k];
            rec.payload = held_payload[k];
            rec.is_last = (k + 1 == limit);
            sorted_expect.insert(sorted_expect.size(), rec);
        end
        run_done = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Monitor and scoreboard: sample every handshake at the rising edge
    // ------------------------------------------------------------------
    logic word_taken = 1'b0;

    always @(posedge clk)
    begin : scoreboard
        sorted_rec_t want;
        if (rst_n)
        begin
            word_taken <= s_tvalid && s_tready;
            // a word taken at the same edge as a count write sees the old count
            if (s_tvalid && s_tready)
            begin
                words_accepted++;
                absorb_packet(s_tdata);
            end
            if (cfg_valid && cfg_ready)
            begin
                count_setting = cfg_data;
                cfg_writes++;
            end
            if (m_tvalid && m_tready)
            begin
                if (sorted_expect.size() == 0)
                begin
                    $error("unexpected output word: id %h payload %h last %b",
                           m_tdata[ID_W-1:0], m_tdata[DATA_W-1:ID_W], m_tlast);
                    fail_count++;
                end
                else
                begin
                    want = sorted_expect.pop_front();
                    records_checked++;
                    if (m_tdata[ID_W-1:0] !== want.id)
                    begin
                        $error("sorted_id mismatch: expected %h, got %h",
                               want.id, m_tdata[ID_W-1:0]);
                        fail_count++;
                    end
                    if (m_tdata[DATA_W-1:ID_W] !== want.payload)
                    begin
                        $error("sorted_payload mismatch: expected %h, got %h",
                               want.payload, m_tdata[DATA_W-1:ID_W]);
                        fail_count++;
                    end
                    if (m_tlast !== want.is_last)
                    begin
                        $error("last_record mismatch: expected %b, got %b",
                               want.is_last, m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        else
            word_taken <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps
    // ------------------------------------------------------------------
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge clk)
    begin
        // hold the current word until it is taken
        if (rst_n && (!s_tvalid || word_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                s_tdata  <= pending_words.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    // about a quarter of the bursts run straight into the next
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Output receiver: stall mode is redrawn at random among three modes
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_age   = 0;

    always @(negedge clk)
    begin
        if (mode_age == 63)
        begin
            mode_age   = 0;
            stall_mode = $urandom_range(0, 2);
        end
        else
            mode_age++;
        case (stall_mode)
            0:       m_tready <= 1'b1;                        // never stall
            1:       m_tready <= 1'($urandom_range(0, 1));    // coin toss
            default: m_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
        endcase
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL packet_reorder_sorter");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_count(input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_word(input logic [ID_W-1:0] id,
                              input logic [OUT_PAYLOAD_W-1:0] payload);
        pending_words.insert(pending_words.size(), {payload, id});
    endtask

    // random word, biased toward duplicate and extreme identifiers
    task automatic queue_random_word();
        logic [ID_W-1:0] id;
        case ($urandom_range(0, 3))
            1:       id = 16'($urandom_range(0, 7));
            2:       id = 16'hFFF8 + 16'($urandom_range(0, 7));
            default: id = 16'($urandom);
        endcase
        queue_word(id, $urandom);
    endtask

    task automatic wait_inputs_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || s_tvalid);
    endtask

    initial
    begin : stimulus
        int load_words;
        int lowered_count;
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the count register through its extremes while idle; the last
        // value (above the store size) is what the load runs under.
        write_count(7'd0);
        write_count(7'd1);
        write_count(7'd64);
        write_count(7'd127);

        // Directed words: field extremes, duplicate keys in both orders,
        // sign-bit patterns and a strictly descending run.
        queue_word(16'h0000, 32'h0000_0000);
        queue_word(16'hFFFF, 32'hFFFF_FFFF);
        queue_word(16'hFFFF, 32'h0000_0000);
        queue_word(16'h0000, 32'hFFFF_FFFF);
        queue_word(16'h8000, 32'h8000_0000);
        queue_word(16'h7FFF, 32'h7FFF_FFFF);
        queue_word(16'h1234, 32'h0000_0001);
        queue_word(16'h1234, 32'h0000_0002);
        queue_word(16'h1234, 32'h0000_0003);
        queue_word(16'h5555, 32'hAAAA_AAAA);
        queue_word(16'hAAAA, 32'h5555_5555);
        for (int i = 0; i < 9; i++)
            queue_word(16'(16'h0100 - i), 32'hC0DE_0000 + i);

        // Random words up to a load of 40..63, short of the 64 the register
        // allows, so the load is still open when the count is lowered.
        load_words = $urandom_range(40, 63);
        while (pending_words.size() < load_words)
            queue_random_word();
        wait_inputs_drained();
        repeat (8) @(negedge clk);

        // Lower the count to at or below what is held: the next word is
        // dropped and starts the sort of the first lowered_count records.
        lowered_count = $urandom_range(load_words - 6, load_words);
        write_count(lowered_count[CFG_W-1:0]);

        // trigger word, then words that arrive after the run and are ignored
        for (int i = 0; i < AFTER_RUN_WORDS + 1; i++)
            queue_random_word();
        wait_inputs_drained();

        while (sorted_expect.size() != 0)
            @(negedge clk);
        // catch anything the block emits beyond the run
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Loaded %0d of %0d words, sorted and checked %0d records.",
                 load_words, words_accepted, records_checked);
        $display("Dropped %0d words after the count was met; %0d count writes.",
                 words_dropped, cfg_writes);
        if (fail_count == 0)
            $display("PASS packet_reorder_sorter");
        else
            $display("FAIL packet_reorder_sorter");
        $finish;
    end

endmodule
